/* rtl/ptcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-vcpu timer comparator package
// Shared constants, opcodes and structures of the per-vcpu timer block.
// ----------------------------------------------------------------------------
package ptcr_pkg;

  localparam int unsigned NumVcpus = 8;
  localparam int unsigned VcpuIdxW = (NumVcpus > 1) ? $clog2(NumVcpus) : 1;

  localparam int unsigned CtlEnableBit = 0;
  localparam int unsigned CtlImaskBit  = 1;

  localparam logic [2:0]  CtlReset = 3'd2;
  localparam logic [63:0] TvalDisabledValue = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_CTL_READ   = 3'd0,
    OP_CTL_WRITE  = 3'd1,
    OP_CVAL_READ  = 3'd2,
    OP_CVAL_WRITE = 3'd3,
    OP_TVAL_READ  = 3'd4,
    OP_TVAL_WRITE = 3'd5,
    OP_TICK       = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]  ctl;
    logic [63:0] cval;
    logic        armed;
    logic [63:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] write_data;
    logic [63:0] counter_now;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        inject_irq;
    logic        remove_irq;
  } result_t;

endpackage
`default_nettype wire

/* rtl/per_vcpu_timer_compare_regs_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-vcpu generic timer comparator
// Holds the CTL, CVAL and armed deadline of each vcpu's physical timer and
// answers register accesses and ticks with one result per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its output is not stalled.
// The item is captured in an input register, the addressed vcpu entry is
// read, compared and rewritten as the result is loaded, and the result is
// held in an output register until it is taken. The entry table is read
// and written in the same cycle as the result register is loaded, so
// back-to-back items to one vcpu see each other's updates. Items for a
// vcpu index beyond the table and unused opcodes give an all-zero result.
module per_vcpu_timer_compare_regs_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [2:0]  vcpu_i,
  input  wire logic [63:0] write_data_i,
  input  wire logic [63:0] counter_now_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [63:0] read_data_o,
  output      logic        inject_irq_o,
  output      logic        remove_irq_o
);

  logic                          in_valid_q;
  logic [2:0]                    vcpu_q;
  ptcr_pkg::item_t               item_q;
  logic                          out_valid_q;
  ptcr_pkg::result_t             result_q;
  ptcr_pkg::entry_t              entries_q [ptcr_pkg::NumVcpus];
  ptcr_pkg::entry_t              entry_rd;
  ptcr_pkg::entry_t              entry_d;
  ptcr_pkg::result_t             result_d;
  logic [ptcr_pkg::VcpuIdxW-1:0] vcpu_idx;
  logic                          in_range;
  logic                          out_load;
  logic                          in_load;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = !in_stall_o;

  assign vcpu_idx = ptcr_pkg::VcpuIdxW'(vcpu_q);
  assign in_range = int'(vcpu_q) < ptcr_pkg::NumVcpus;
  assign entry_rd = entries_q[vcpu_idx];

  ptcr_entry_update u_entry_update (
    .item_i   (item_q),
    .entry_i  (entry_rd),
    .entry_o  (entry_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      vcpu_q             <= vcpu_i;
      item_q.opcode      <= opcode_i;
      item_q.write_data  <= write_data_i;
      item_q.counter_now <= counter_now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptcr_pkg::NumVcpus; i++) begin
        entries_q[i].ctl      <= ptcr_pkg::CtlReset;
        entries_q[i].cval     <= '0;
        entries_q[i].armed    <= 1'b0;
        entries_q[i].deadline <= '0;
      end
    end else if (in_valid_q && out_load && in_range) begin
      entries_q[vcpu_idx] <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      result_q <= in_range ? result_d : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = result_q.read_data;
  assign inject_irq_o = result_q.inject_irq;
  assign remove_irq_o = result_q.remove_irq;

endmodule
`default_nettype wire

/* rtl/ptcr_entry_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-vcpu timer entry update
// Computes the result of one access or tick and the new state of the
// addressed vcpu's timer entry.
// ----------------------------------------------------------------------------
module ptcr_entry_update (
  input  ptcr_pkg::item_t   item_i,
  input  ptcr_pkg::entry_t  entry_i,
  output ptcr_pkg::entry_t  entry_o,
  output ptcr_pkg::result_t result_o
);

  logic        timer_on;
  logic        new_on;
  logic [63:0] tval_ext;
  logic [63:0] new_cval;
  logic [63:0] sched_cval;
  logic        sched_below;
  logic [63:0] tval_diff;
  logic        tick_due;

  assign timer_on = entry_i.ctl[ptcr_pkg::CtlEnableBit] & ~entry_i.ctl[ptcr_pkg::CtlImaskBit];
  assign new_on   = item_i.write_data[ptcr_pkg::CtlEnableBit]
                  & ~item_i.write_data[ptcr_pkg::CtlImaskBit];
  assign tval_ext = {{32{item_i.write_data[31]}}, item_i.write_data[31:0]};
  assign new_cval = (item_i.opcode == ptcr_pkg::OP_CVAL_WRITE) ? item_i.write_data
                                                               : tval_ext + item_i.counter_now;
  assign sched_cval = ((item_i.opcode == ptcr_pkg::OP_CVAL_WRITE) ||
                       (item_i.opcode == ptcr_pkg::OP_TVAL_WRITE)) ? new_cval : entry_i.cval;
  assign sched_below = sched_cval < item_i.counter_now;
  assign tval_diff   = entry_i.cval - item_i.counter_now;
  assign tick_due    = entry_i.armed && (item_i.counter_now >= entry_i.deadline);

  always_comb begin
    entry_o  = entry_i;
    result_o = '0;
    unique case (item_i.opcode)
      ptcr_pkg::OP_CTL_READ: begin
        result_o.read_data = {61'd0, sched_below, entry_i.ctl[1:0]};
      end
      ptcr_pkg::OP_CTL_WRITE: begin
        entry_o.ctl = item_i.write_data[2:0];
        if (!timer_on && new_on) begin
          if (sched_below) begin
            result_o.inject_irq = 1'b1;
          end else begin
            entry_o.armed    = 1'b1;
            entry_o.deadline = entry_i.cval;
          end
        end
      end
      ptcr_pkg::OP_CVAL_READ: begin
        result_o.read_data = entry_i.cval;
      end
      ptcr_pkg::OP_CVAL_WRITE, ptcr_pkg::OP_TVAL_WRITE: begin
        entry_o.cval = new_cval;
        if (timer_on) begin
          result_o.remove_irq = 1'b1;
          if (sched_below) begin
            entry_o.armed       = 1'b0;
            result_o.inject_irq = 1'b1;
          end else begin
            entry_o.armed    = 1'b1;
            entry_o.deadline = new_cval;
          end
        end
      end
      ptcr_pkg::OP_TVAL_READ: begin
        if (!entry_i.ctl[ptcr_pkg::CtlEnableBit]) begin
          result_o.read_data = ptcr_pkg::TvalDisabledValue;
        end else begin
          result_o.read_data = {32'd0, tval_diff[31:0]};
        end
      end
      ptcr_pkg::OP_TICK: begin
        if (tick_due) begin
          entry_o.armed       = 1'b0;
          result_o.inject_irq = 1'b1;
        end
      end
      default: begin
        entry_o  = entry_i;
        result_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/ptcr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Per-vcpu timer comparator checker
// Port-level checks of the result channel and the input back-pressure.
// ----------------------------------------------------------------------------
module ptcr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] read_data_o,
  input wire logic        inject_irq_o,
  input wire logic        remove_irq_o
);

  // A pending result is held until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result changed while stalled");

  // The input side is held back only by a stalled, full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A withdrawal only comes from a write, which returns no read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && remove_irq_o |-> read_data_o == 64'd0)
    else $error("withdrawal carries read data");

  // A read result never injects or withdraws the interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != 64'd0) |-> !inject_irq_o && !remove_irq_o)
    else $error("read result carries an interrupt event");

endmodule

bind per_vcpu_timer_compare_regs_unit ptcr_checker u_ptcr_checker (.*);
`default_nettype wire
